// File: design/doeq_pkg.sv
// Shared types and codes for the deadline ordered event queue.
// Transaction structs, stored entry layout and status codes; no dependencies.
`default_nettype none
package doeq_pkg;

	localparam logic [1:0] StInserted = 2'd0;
	localparam logic [1:0] StFull     = 2'd1;
	localparam logic [1:0] StRemoved  = 2'd2;
	localparam logic [1:0] StEmpty    = 2'd3;

	localparam logic ModeInsert = 1'b0;
	localparam logic ModePop    = 1'b1;

	typedef struct packed {
		logic        mode;
		logic [31:0] deadline_secs;
		logic [29:0] deadline_nsecs;
		logic [31:0] stamp_secs;
		logic [29:0] stamp_nsecs;
		logic [15:0] micro_step;
		logic [15:0] graph_depth;
		logic [7:0]  actor_id;
		logic [7:0]  sink_port;
		logic [63:0] payload;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] out_deadline_secs;
		logic [29:0] out_deadline_nsecs;
		logic [31:0] out_stamp_secs;
		logic [29:0] out_stamp_nsecs;
		logic [15:0] out_micro_step;
		logic [15:0] out_graph_depth;
		logic [7:0]  out_actor_id;
		logic [7:0]  out_sink_port;
		logic [63:0] out_payload;
		logic        last;
	} rsp_t;

	typedef struct packed {
		logic [61:0] deadline;
		logic [61:0] stamp;
		logic [15:0] step;
		logic [15:0] depth;
		logic [7:0]  actor;
		logic [7:0]  port;
		logic [63:0] payload;
	} entry_t;

endpackage
`default_nettype wire

// File: design/deadline_ordered_event_queue.sv
// Deadline ordered event queue, top level. Entries sit in a circular buffer in
// doeq_store; uses doeq_pkg. An insert into an empty or full queue goes from idle
// straight to its status; one that lands at the head or beside a single entry needs
// a head read only, else it scans from the tail (one store read per step). A pop
// reads the head and then each further event of the group; results leave one per
// cycle without output stall. Status results pass through the output
// register. No clearing pass.
`default_nettype none
module deadline_ordered_event_queue #(
	parameter int QUEUE_DEPTH = 64,
	parameter int ACTOR_BITS  = 8
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 req_valid,
	output logic                req_stall,
	input  wire doeq_pkg::req_t req,
	output logic                rsp_valid,
	input  wire                 rsp_stall,
	output doeq_pkg::rsp_t      rsp
);

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [7:0] ActorMask = (ACTOR_BITS >= 8) ? 8'hFF : 8'((1 << ACTOR_BITS) - 1);

	typedef enum logic [7:0] {
		S_IDLE     = 8'b0000_0001,
		S_INS_HEAD = 8'b0000_0010,
		S_INS_SCAN = 8'b0000_0100,
		S_INS_PUT  = 8'b0000_1000,
		S_POP_HEAD = 8'b0001_0000,
		S_POP_SCAN = 8'b0010_0000,
		S_POP_LAST = 8'b0100_0000,
		S_RESP     = 8'b1000_0000
	} state_t;

	state_t             state_q, state_d;
	logic [PW-1:0]      head_q, head_d;
	logic [CW-1:0]      count_q, count_d;
	logic [CW-1:0]      pos_q, pos_d;
	doeq_pkg::entry_t   new_q, new_d;
	doeq_pkg::entry_t   cur_q, cur_d;
	logic [1:0]         status_q, status_d;
	doeq_pkg::rsp_t     rsp_q, rsp_d;
	logic               rsp_valid_q, load_rsp;

	logic               wr_en, rd_en;
	logic [PW-1:0]      wr_addr, rd_addr;
	doeq_pkg::entry_t   wr_data, rd_data;
	logic               out_free, grp_match;
	logic [155:0]       key_new, key_rd;

	function automatic doeq_pkg::entry_t mk_entry(input doeq_pkg::req_t r);
		doeq_pkg::entry_t e;
		e.deadline = {r.deadline_secs, r.deadline_nsecs};
		e.stamp    = {r.stamp_secs, r.stamp_nsecs};
		e.step     = r.micro_step;
		e.depth    = r.graph_depth;
		e.actor    = r.actor_id & ActorMask;
		e.port     = r.sink_port;
		e.payload  = r.payload;
		return e;
	endfunction

	function automatic logic [PW-1:0] phys(input logic [PW-1:0] h, input logic [CW-1:0] off);
		logic [PW:0] s;
		s = {1'b0, h} + (PW+1)'(off);
		if (s >= (PW+1)'(QUEUE_DEPTH)) begin
			s = s - (PW+1)'(QUEUE_DEPTH);
		end
		return s[PW-1:0];
	endfunction

	function automatic doeq_pkg::rsp_t mk_rsp(input doeq_pkg::entry_t e, input logic lst);
		doeq_pkg::rsp_t o;
		o.status             = doeq_pkg::StRemoved;
		o.out_deadline_secs  = e.deadline[61:30];
		o.out_deadline_nsecs = e.deadline[29:0];
		o.out_stamp_secs     = e.stamp[61:30];
		o.out_stamp_nsecs    = e.stamp[29:0];
		o.out_micro_step     = e.step;
		o.out_graph_depth    = e.depth;
		o.out_actor_id       = e.actor;
		o.out_sink_port      = e.port;
		o.out_payload        = e.payload;
		o.last               = lst;
		return o;
	endfunction

	doeq_store #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign key_new   = {new_q.deadline, new_q.stamp, new_q.step, new_q.depth};
	assign key_rd    = {rd_data.deadline, rd_data.stamp, rd_data.step, rd_data.depth};
	assign grp_match = (rd_data.stamp == cur_q.stamp) && (rd_data.step == cur_q.step) &&
		(rd_data.actor == cur_q.actor);

	always_comb begin
		state_d  = state_q;
		head_d   = head_q;
		count_d  = count_q;
		pos_d    = pos_q;
		new_d    = new_q;
		cur_d    = cur_q;
		status_d = status_q;
		rsp_d    = '0;
		load_rsp = 1'b0;
		wr_en    = 1'b0;
		wr_addr  = head_q;
		wr_data  = new_q;
		rd_en    = 1'b0;
		rd_addr  = head_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					new_d = mk_entry(req);
					if (req.mode == doeq_pkg::ModeInsert) begin
						if (count_q == CW'(QUEUE_DEPTH)) begin
							status_d = doeq_pkg::StFull;
							state_d  = S_RESP;
						end else if (count_q == '0) begin
							wr_en    = 1'b1;
							wr_data  = mk_entry(req);
							count_d  = count_q + 1'b1;
							status_d = doeq_pkg::StInserted;
							state_d  = S_RESP;
						end else begin
							rd_en   = 1'b1;
							state_d = S_INS_HEAD;
						end
					end else begin
						if (count_q == '0) begin
							status_d = doeq_pkg::StEmpty;
							state_d  = S_RESP;
						end else begin
							rd_en   = 1'b1;
							state_d = S_POP_HEAD;
						end
					end
				end
			end
			S_INS_HEAD: begin
				if (key_new <= key_rd) begin
					head_d   = (head_q == '0) ? PW'(QUEUE_DEPTH - 1) : head_q - 1'b1;
					wr_en    = 1'b1;
					wr_addr  = head_d;
					count_d  = count_q + 1'b1;
					status_d = doeq_pkg::StInserted;
					state_d  = S_RESP;
				end else if (count_q == CW'(1)) begin
					wr_en    = 1'b1;
					wr_addr  = phys(head_q, CW'(1));
					count_d  = count_q + 1'b1;
					status_d = doeq_pkg::StInserted;
					state_d  = S_RESP;
				end else begin
					rd_en   = 1'b1;
					rd_addr = phys(head_q, count_q - 1'b1);
					pos_d   = count_q;
					state_d = S_INS_SCAN;
				end
			end
			S_INS_SCAN: begin
				if (key_new < key_rd) begin
					wr_en   = 1'b1;
					wr_addr = phys(head_q, pos_q);
					wr_data = rd_data;
					pos_d   = pos_q - 1'b1;
					if (pos_q - 1'b1 > CW'(1)) begin
						rd_en   = 1'b1;
						rd_addr = phys(head_q, pos_q - CW'(2));
					end else begin
						state_d = S_INS_PUT;
					end
				end else begin
					wr_en    = 1'b1;
					wr_addr  = phys(head_q, pos_q);
					count_d  = count_q + 1'b1;
					status_d = doeq_pkg::StInserted;
					state_d  = S_RESP;
				end
			end
			S_INS_PUT: begin
				wr_en    = 1'b1;
				wr_addr  = phys(head_q, pos_q);
				count_d  = count_q + 1'b1;
				status_d = doeq_pkg::StInserted;
				state_d  = S_RESP;
			end
			S_POP_HEAD: begin
				cur_d = rd_data;
				pos_d = CW'(1);
				if (count_q > CW'(1)) begin
					rd_en   = 1'b1;
					rd_addr = phys(head_q, CW'(1));
					state_d = S_POP_SCAN;
				end else begin
					state_d = S_POP_LAST;
				end
			end
			S_POP_SCAN: begin
				if (out_free) begin
					load_rsp = 1'b1;
					rsp_d    = mk_rsp(cur_q, !grp_match);
					if (grp_match) begin
						cur_d = rd_data;
						pos_d = pos_q + 1'b1;
						if (pos_q + 1'b1 < count_q) begin
							rd_en   = 1'b1;
							rd_addr = phys(head_q, pos_q + 1'b1);
						end else begin
							state_d = S_POP_LAST;
						end
					end else begin
						head_d  = phys(head_q, pos_q);
						count_d = count_q - pos_q;
						state_d = S_IDLE;
					end
				end
			end
			S_POP_LAST: begin
				if (out_free) begin
					load_rsp = 1'b1;
					rsp_d    = mk_rsp(cur_q, 1'b1);
					head_d   = phys(head_q, pos_q);
					count_d  = count_q - pos_q;
					state_d  = S_IDLE;
				end
			end
			S_RESP: begin
				if (out_free) begin
					load_rsp     = 1'b1;
					rsp_d.status = status_q;
					rsp_d.last   = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			count_q <= count_d;
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		pos_q    <= pos_d;
		new_q    <= new_d;
		cur_q    <= cur_d;
		status_q <= status_d;
		if (load_rsp) begin
			rsp_q <= rsp_d;
		end
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QUEUE_DEPTH))
		else $error("entry count above depth");

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("state not one-hot");

	a_full_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && req_valid && req.mode == doeq_pkg::ModeInsert &&
		count_q == CW'(QUEUE_DEPTH)) |=> (count_q == $past(count_q)))
		else $error("full insert changed the queue");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_POP_SCAN || state_q == S_POP_LAST) |-> (count_q != '0 && pos_q <= count_q))
		else $error("pop group beyond stored entries");

endmodule
`default_nettype wire

// File: design/doeq_store.sv
// Entry store of the event queue: one write port, one read port, registered read.
// Uses doeq_pkg::entry_t.
`default_nettype none
module doeq_store #(
	parameter int QUEUE_DEPTH = 64
) (
	input  wire                             clk,
	input  wire                             wr_en,
	input  wire [$clog2(QUEUE_DEPTH)-1:0]   wr_addr,
	input  wire doeq_pkg::entry_t           wr_data,
	input  wire                             rd_en,
	input  wire [$clog2(QUEUE_DEPTH)-1:0]   rd_addr,
	output doeq_pkg::entry_t                rd_data
);

	doeq_pkg::entry_t mem [QUEUE_DEPTH];
	doeq_pkg::entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
`default_nettype wire

// File: sim/doeq_checker.sv
// Checker for the deadline ordered event queue: watches both channels, keeps a
// sorted queue of its own and compares every response transaction. Uses doeq_pkg.
`default_nettype none
module doeq_checker #(
	parameter int QUEUE_DEPTH = 64,
	parameter int ACTOR_BITS  = 8
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 req_valid,
	input  wire                 req_stall,
	input  wire doeq_pkg::req_t req,
	input  wire                 rsp_valid,
	input  wire                 rsp_stall,
	input  wire doeq_pkg::rsp_t rsp,
	output int                  fail_count,
	output int                  pending,
	output int                  popped_events,
	output int                  full_rejects
);

	doeq_pkg::entry_t events[$];
	doeq_pkg::rsp_t   want_rsp[$];

	function automatic logic [155:0] sort_key(doeq_pkg::entry_t e);
		return {e.deadline, e.stamp, e.step, e.depth};
	endfunction

	function automatic doeq_pkg::rsp_t status_rsp(logic [1:0] st);
		doeq_pkg::rsp_t r;
		r = '0;
		r.status = st;
		r.last = 1'b1;
		return r;
	endfunction

	task automatic schedule(doeq_pkg::req_t t);
		doeq_pkg::entry_t e;
		doeq_pkg::rsp_t r;
		int pos;
		int n;
		if (t.mode == doeq_pkg::ModeInsert) begin
			if (events.size() >= QUEUE_DEPTH) begin
				want_rsp.push_back(status_rsp(doeq_pkg::StFull));
				full_rejects++;
				return;
			end
			e.deadline = {t.deadline_secs, t.deadline_nsecs};
			e.stamp = {t.stamp_secs, t.stamp_nsecs};
			e.step = t.micro_step;
			e.depth = t.graph_depth;
			e.actor = t.actor_id & 8'((1 << ACTOR_BITS) - 1);
			e.port = t.sink_port;
			e.payload = t.payload;
			if (events.size() == 0 || sort_key(e) <= sort_key(events[0])) begin
				pos = 0;
			end else begin
				pos = events.size();
				while (pos > 1 && sort_key(e) < sort_key(events[pos - 1]))
					pos--;
			end
			events.insert(pos, e);
			want_rsp.push_back(status_rsp(doeq_pkg::StInserted));
		end else begin
			if (events.size() == 0) begin
				want_rsp.push_back(status_rsp(doeq_pkg::StEmpty));
				return;
			end
			n = 1;
			while (n < events.size() && events[n].stamp == events[0].stamp &&
					events[n].step == events[0].step && events[n].actor == events[0].actor)
				n++;
			for (int i = 0; i < n; i++) begin
				e = events.pop_front();
				r.status = doeq_pkg::StRemoved;
				r.out_deadline_secs = e.deadline[61:30];
				r.out_deadline_nsecs = e.deadline[29:0];
				r.out_stamp_secs = e.stamp[61:30];
				r.out_stamp_nsecs = e.stamp[29:0];
				r.out_micro_step = e.step;
				r.out_graph_depth = e.depth;
				r.out_actor_id = e.actor;
				r.out_sink_port = e.port;
				r.out_payload = e.payload;
				r.last = (i == n - 1);
				want_rsp.push_back(r);
				popped_events++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		doeq_pkg::rsp_t w;
		if (!arst_n) begin
			fail_count <= 0;
			popped_events = 0;
			full_rejects = 0;
			pending = 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (want_rsp.size() == 0) begin
					if (fail_count < 10)
						$display("checker: unexpected transaction %h", rsp);
					fail_count <= fail_count + 1;
				end else begin
					w = want_rsp.pop_front();
					if (w !== rsp) begin
						if (fail_count < 10)
							$display("checker: mismatch exp %h got %h", w, rsp);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (req_valid && !req_stall)
				schedule(req);
			pending = want_rsp.size();
		end
	end
endmodule
`default_nettype wire

// File: sim/tb.sv
// Testbench top for the deadline ordered event queue: directed and random
// insert/pop stimulus with random gaps and stalls. Uses doeq_pkg and doeq_checker.
`default_nettype none
module tb;

	localparam int DEPTH = 64;
	localparam int WATCHDOG = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	doeq_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	doeq_pkg::rsp_t rsp;
	int fail_count, pending, popped_events, full_rejects;
	int idle_cycles = 0;
	int stall_left = 0;
	int sent = 0;
	bit ext_burst = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	deadline_ordered_event_queue #(.QUEUE_DEPTH(DEPTH), .ACTOR_BITS(8)) dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	doeq_checker #(.QUEUE_DEPTH(DEPTH), .ACTOR_BITS(8)) chk (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.fail_count(fail_count), .pending(pending),
		.popped_events(popped_events), .full_rejects(full_rejects)
	);

	function automatic int gap_len();
		if ($urandom_range(0, 3) == 0)
			return 0;
		return ($urandom_range(0, 19) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (stall_left > 0) begin
				rsp_stall <= 1'b1;
				stall_left <= stall_left - 1;
			end else if (ext_burst) begin
				rsp_stall <= 1'b0;
			end else if ($urandom_range(0, 49) == 0) begin
				rsp_stall <= 1'b1;
				stall_left <= $urandom_range(8, 40);
			end else begin
				rsp_stall <= ($urandom_range(0, 9) < 3);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("tb: watchdog expired");
			$display("tb: FAIL");
			$finish;
		end
	end

	function automatic doeq_pkg::req_t rand_event(int group);
		doeq_pkg::req_t t;
		t.mode = doeq_pkg::ModeInsert;
		t.deadline_secs = $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 7);
		t.deadline_nsecs = 30'($urandom_range(0, 7) == 0 ? $urandom() : $urandom_range(0, 3));
		t.stamp_secs = group >= 0 ? 32'(group) : $urandom();
		t.stamp_nsecs = group >= 0 ? 30'd5 : 30'($urandom());
		t.micro_step = group >= 0 ? 16'd1 : 16'($urandom());
		t.graph_depth = $urandom_range(0, 1) ? 16'($urandom()) : 16'($urandom_range(0, 3));
		t.actor_id = group >= 0 ? 8'(group) : 8'($urandom());
		t.sink_port = 8'($urandom());
		t.payload = {$urandom(), $urandom()};
		return t;
	endfunction

	task automatic send(doeq_pkg::req_t t);
		int g;
		g = ext_burst ? 0 : gap_len();
		if (g > 0) begin
			req_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		req <= t;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		sent++;
	endtask

	task automatic pop_req();
		doeq_pkg::req_t t;
		t = '0;
		t.mode = doeq_pkg::ModePop;
		t[$bits(doeq_pkg::req_t)-2:0] = ($bits(doeq_pkg::req_t)-1)'({$urandom(), $urandom(),
			$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
			$urandom()});
		send(t);
	endtask

	initial begin
		doeq_pkg::req_t t;
		int grp;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		pop_req();
		t = '1;
		t.mode = doeq_pkg::ModeInsert;
		send(t);
		pop_req();
		t = '0;
		send(t);
		t.payload = '1;
		send(t);
		t = rand_event(9);
		send(t);
		pop_req();
		pop_req();
		for (int i = 0; i < 4; i++) send(rand_event(3));
		send(rand_event(-1));
		pop_req();
		pop_req();
		pop_req();
		ext_burst = 1'b1;
		for (int i = 0; i < DEPTH + 2; i++) send(rand_event($urandom_range(0, 1) ? 2 : -1));
		ext_burst = 1'b0;
		while (sent < 100) pop_req();
		for (int i = 0; i < 200; i++) begin
			if ($urandom_range(0, 9) < 6) begin
				grp = $urandom_range(0, 2) == 0 ? -1 : $urandom_range(0, 3);
				send(rand_event(grp));
			end else begin
				pop_req();
			end
			if (i % 100 == 50) ext_burst = 1'b1;
			if (i % 100 == 80) ext_burst = 1'b0;
		end
		req_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (80) @(posedge clk);
		$display("tb: %0d requests sent, %0d events popped, %0d full rejects",
			sent, popped_events, full_rejects);
		if (fail_count == 0 && pending == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end
endmodule
`default_nettype wire
